/* design/dehp_pkg.sv */
// Shared types and constants for the dual encoder hysteresis period meter.
`default_nettype none

package dehp_pkg;

  localparam int CHANNELS     = 2;
  localparam int SAMPLE_BITS  = 12;
  localparam int COUNTER_BITS = 32;
  localparam int PERIOD_BITS  = 16;
  localparam int APB_DATA_BITS = 32;

  // Two registers (upper, lower) per channel, one word apart.
  localparam int REG_COUNT = 2 * CHANNELS;
  localparam int REG_IDX_BITS = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int ADDR_BITS = REG_IDX_BITS + 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Register map codes.
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_UPPER_A = 2'd0,
    REG_LOWER_A = 2'd1,
    REG_UPPER_B = 2'd2,
    REG_LOWER_B = 2'd3
  } reg_idx_t;

  localparam sample_t [CHANNELS-1:0] UPPER_RESET = {12'd1000, 12'd2500};
  localparam sample_t [CHANNELS-1:0] LOWER_RESET = {12'd750, 12'd1500};

  typedef struct packed {
    sample_t [CHANNELS-1:0] upper;
    sample_t [CHANNELS-1:0] lower;
  } thr_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic                   rise;
    logic                   level;
  } ch_res_t;

endpackage

`default_nettype wire

/* design/dehp_regs.sv */
// APB threshold register file for the hysteresis period meter.
`default_nettype none

module dehp_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [dehp_pkg::ADDR_BITS-1:0]       paddr,
  input  wire logic [dehp_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [dehp_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                      pready,
  output dehp_pkg::thr_t                            thr
);

  dehp_pkg::thr_t    thr_r, thr_nxt;
  dehp_pkg::reg_idx_t idx;
  dehp_pkg::sample_t rd_val;
  logic              wr_en;

  assign idx    = dehp_pkg::reg_idx_t'(paddr[dehp_pkg::ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign thr    = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en) begin
      case (idx)
        dehp_pkg::REG_UPPER_A: thr_nxt.upper[0] = pwdata[dehp_pkg::SAMPLE_BITS-1:0];
        dehp_pkg::REG_LOWER_A: thr_nxt.lower[0] = pwdata[dehp_pkg::SAMPLE_BITS-1:0];
        dehp_pkg::REG_UPPER_B: thr_nxt.upper[1] = pwdata[dehp_pkg::SAMPLE_BITS-1:0];
        dehp_pkg::REG_LOWER_B: thr_nxt.lower[1] = pwdata[dehp_pkg::SAMPLE_BITS-1:0];
        default: thr_nxt = thr_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dehp_pkg::REG_UPPER_A: rd_val = thr_r.upper[0];
      dehp_pkg::REG_LOWER_A: rd_val = thr_r.lower[0];
      dehp_pkg::REG_UPPER_B: rd_val = thr_r.upper[1];
      dehp_pkg::REG_LOWER_B: rd_val = thr_r.lower[1];
      default:               rd_val = '0;
    endcase
  end

  assign prdata = {{(dehp_pkg::APB_DATA_BITS-dehp_pkg::SAMPLE_BITS){1'b0}}, rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.upper <= dehp_pkg::UPPER_RESET;
      thr_r.lower <= dehp_pkg::LOWER_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/dehp_channel.sv */
// One channel: Schmitt trigger, rise timestamp and period capture.
`default_nettype none

module dehp_channel #(
  parameter int COUNTER_BITS = dehp_pkg::COUNTER_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    upd,
  input  wire dehp_pkg::sample_t       sample,
  input  wire dehp_pkg::sample_t       upper,
  input  wire dehp_pkg::sample_t       lower,
  input  wire logic [COUNTER_BITS-1:0] tick,
  output dehp_pkg::ch_res_t            res
);

  logic                            level_r, level_nxt;
  logic [COUNTER_BITS-1:0]         rise_time_r, rise_time_nxt;
  logic [dehp_pkg::PERIOD_BITS-1:0] period_r, period_nxt;
  logic [COUNTER_BITS-1:0]         elapsed;
  logic                            rise;

  // Modular difference wraps naturally at the counter width.
  assign elapsed = tick - rise_time_r;
  assign rise    = !level_r && (sample > upper);

  always_comb begin
    level_nxt     = level_r;
    rise_time_nxt = rise_time_r;
    period_nxt    = period_r;
    if (rise) begin
      level_nxt     = 1'b1;
      rise_time_nxt = tick;
      period_nxt    = elapsed[dehp_pkg::PERIOD_BITS-1:0];
    end else if (level_r && (sample < lower)) begin
      level_nxt = 1'b0;
    end
  end

  assign res.period = period_nxt;
  assign res.rise   = rise;
  assign res.level  = level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      rise_time_r <= '0;
      period_r    <= '0;
    end else if (upd) begin
      level_r     <= level_nxt;
      rise_time_r <= rise_time_nxt;
      period_r    <= period_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/dual_encoder_hysteresis_period.sv */
// Top level of the dual encoder hysteresis period meter.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_ready  in_sample_a, in_sample_b
//  out_     output     out_valid/out_ready out_period_a/b, out_rise_a/b, out_level_a/b
//  cfg      APB slave  psel/penable/pready paddr, pwdata, prdata (4 threshold regs)
//
// One transaction per cycle sustained while the output is not stalled; the result
// passes the input register, then the result register, before it is valid.
// The per-channel compare and the counter subtract sit between the two registers.
// rst_n is synchronous: it clears valids, channel state, tick counter, thresholds.
// A stalled output holds its result; the input register still takes one more
// transaction, and only then in_ready drops.
`default_nettype none

module dual_encoder_hysteresis_period #(
  parameter int COUNTER_BITS = dehp_pkg::COUNTER_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [dehp_pkg::SAMPLE_BITS-1:0]   in_sample_a,
  input  wire logic [dehp_pkg::SAMPLE_BITS-1:0]   in_sample_b,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [dehp_pkg::PERIOD_BITS-1:0]   out_period_a,
  output logic      [dehp_pkg::PERIOD_BITS-1:0]   out_period_b,
  output logic                                    out_rise_a,
  output logic                                    out_rise_b,
  output logic                                    out_level_a,
  output logic                                    out_level_b,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dehp_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [dehp_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [dehp_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready
);

  dehp_pkg::thr_t thr;

  // Input stage.
  logic                                      s1_valid_r, s1_valid_nxt;
  dehp_pkg::sample_t [dehp_pkg::CHANNELS-1:0] smp_r;
  // Result stage.
  logic                                      out_valid_r, out_valid_nxt;
  dehp_pkg::ch_res_t [dehp_pkg::CHANNELS-1:0] res_r;
  dehp_pkg::ch_res_t [dehp_pkg::CHANNELS-1:0] res;
  // Tick counter, advanced once per processed transaction.
  logic [COUNTER_BITS-1:0]                   tick_r, tick_nxt;

  logic adv;
  logic in_fire;

  dehp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // Advance the input stage into the result register when that slot frees up.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  genvar ch;
  generate
    for (ch = 0; ch < dehp_pkg::CHANNELS; ch++) begin : g_ch
      dehp_channel #(
        .COUNTER_BITS (COUNTER_BITS)
      ) u_ch (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (adv),
        .sample (smp_r[ch]),
        .upper  (thr.upper[ch]),
        .lower  (thr.lower[ch]),
        .tick   (tick_r),
        .res    (res[ch])
      );
    end
  endgenerate

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign tick_nxt = adv ? (tick_r + 1'b1) : tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
    end
  end

  // Payload registers: load on transfer only, no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r[0] <= in_sample_a;
      smp_r[1] <= in_sample_b;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_period_a = res_r[0].period;
  assign out_period_b = res_r[1].period;
  assign out_rise_a   = res_r[0].rise;
  assign out_rise_b   = res_r[1].rise;
  assign out_level_a  = res_r[0].level;
  assign out_level_b  = res_r[1].level;

  // A rise always leaves the channel high.
  a_rise_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!res_r[0].rise || res_r[0].level) && (!res_r[1].rise || res_r[1].level)))
    else $error("rise reported with channel low");

  // The tick counter moves by exactly one per processed transaction.
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (tick_r == COUNTER_BITS'($past(tick_r) + 1'b1)))
    else $error("tick counter did not advance by one");

  // Back-pressure only when both stages are full and the output is stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

/* bench/dehp_result_checker.sv */
// Watches the sample, result and register ports, predicts each result and compares.
module dehp_result_checker
  import dehp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   in_sample_a,
  input  logic [SAMPLE_BITS-1:0]   in_sample_b,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [PERIOD_BITS-1:0]   out_period_a,
  input  logic [PERIOD_BITS-1:0]   out_period_b,
  input  logic                     out_rise_a,
  input  logic                     out_rise_b,
  input  logic                     out_level_a,
  input  logic                     out_level_b,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  input  logic                     pready,
  output int                       fail_count,
  output int                       pending,
  output int                       checked
);

  // Index 0 is channel A, index 1 channel B.
  typedef ch_res_t [CHANNELS-1:0] tick_res_t;

  sample_t                upper_thr [CHANNELS];
  sample_t                lower_thr [CHANNELS];
  logic [COUNTER_BITS-1:0] tick_cnt;
  logic [COUNTER_BITS-1:0] rise_stamp [CHANNELS];
  logic                   lvl [CHANNELS];
  logic [PERIOD_BITS-1:0] held_period [CHANNELS];
  tick_res_t              due_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  // Advance the meter by one sampling tick and return the result it produces.
  function automatic tick_res_t meter_tick(input sample_t sa, input sample_t sb);
    tick_res_t               res;
    sample_t                 smp [CHANNELS];
    logic [COUNTER_BITS-1:0] elapsed;
    smp[0] = sa;
    smp[1] = sb;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      res[ch].rise = 1'b0;
      if (!lvl[ch]) begin
        if (smp[ch] > upper_thr[ch]) begin
          elapsed         = tick_cnt - rise_stamp[ch];
          held_period[ch] = elapsed[PERIOD_BITS-1:0];
          rise_stamp[ch]  = tick_cnt;
          lvl[ch]         = 1'b1;
          res[ch].rise    = 1'b1;
        end
      end else if (smp[ch] < lower_thr[ch]) begin
        lvl[ch] = 1'b0;
      end
      res[ch].period = held_period[ch];
      res[ch].level  = lvl[ch];
    end
    tick_cnt = tick_cnt + 1'b1;
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tick_res_t want;
    if (!rst_n) begin
      tick_cnt = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        upper_thr[ch]   = UPPER_RESET[ch];
        lower_thr[ch]   = LOWER_RESET[ch];
        rise_stamp[ch]  = '0;
        lvl[ch]         = 1'b0;
        held_period[ch] = '0;
      end
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
          REG_UPPER_A: upper_thr[0] = pwdata[SAMPLE_BITS-1:0];
          REG_LOWER_A: lower_thr[0] = pwdata[SAMPLE_BITS-1:0];
          REG_UPPER_B: upper_thr[1] = pwdata[SAMPLE_BITS-1:0];
          REG_LOWER_B: lower_thr[1] = pwdata[SAMPLE_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with no expected result pending");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          checked++;
          check_field("period_a", want[0].period, out_period_a);
          check_field("period_b", want[1].period, out_period_b);
          check_field("rise_a",   want[0].rise,   out_rise_a);
          check_field("rise_b",   want[1].rise,   out_rise_b);
          check_field("level_a",  want[0].level,  out_level_a);
          check_field("level_b",  want[1].level,  out_level_b);
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(meter_tick(in_sample_a, in_sample_b));
    end
    pending = due_results.size();
  end

endmodule

/* bench/dual_encoder_hysteresis_period_tb.sv */
// Stimulus, handshake pacing and verdict for the dual encoder hysteresis period meter.
module dual_encoder_hysteresis_period_tb;
  import dehp_pkg::*;

  localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 500;   // idle cycles with no transaction on either side
  localparam int QUIET_TICKS    = 30;    // ticks that channel A sits frozen high

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_ready;
  logic [SAMPLE_BITS-1:0]   in_sample_a;
  logic [SAMPLE_BITS-1:0]   in_sample_b;
  logic                     out_valid;
  logic                     out_ready;
  logic [PERIOD_BITS-1:0]   out_period_a;
  logic [PERIOD_BITS-1:0]   out_period_b;
  logic                     out_rise_a;
  logic                     out_rise_b;
  logic                     out_level_a;
  logic                     out_level_b;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_BITS-1:0]     paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int fail_count;
  int pending;
  int checked;

  // Stimulus-side copy of the thresholds, used only to aim samples near them.
  sample_t up_lvl [CHANNELS];
  sample_t lo_lvl [CHANNELS];
  int      wave_pos [CHANNELS];
  int      wave_len [CHANNELS];
  bit      no_idle;      // when set, neither side inserts gaps or stalls
  int      ticks_sent;
  int      settings_used;
  int      idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_encoder_hysteresis_period DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_a  (in_sample_a),
    .in_sample_b  (in_sample_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_period_a (out_period_a),
    .out_period_b (out_period_b),
    .out_rise_a   (out_rise_a),
    .out_rise_b   (out_rise_b),
    .out_level_a  (out_level_a),
    .out_level_b  (out_level_b),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  dehp_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_a  (in_sample_a),
    .in_sample_b  (in_sample_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_period_a (out_period_a),
    .out_period_b (out_period_b),
    .out_rise_a   (out_rise_a),
    .out_rise_b   (out_rise_b),
    .out_level_a  (out_level_a),
    .out_level_b  (out_level_b),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  // Watchdog: reset the idle count on any transaction, bail out when it runs too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dual_encoder_hysteresis_period regression: fail");
      $finish;
    end
  end

  // Receiver: draw a stall per result, then hold ready until a transaction completes.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Present one tick of samples after a random gap; return at the falling edge
  // after acceptance so the next tick can follow back to back.
  task automatic send_tick(input sample_t sa, input sample_t sb);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_a <= sa;
    in_sample_b <= sb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected result is back, then let the
  // two-stage pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Two-phase register write: setup, then access, then idle with psel low.
  task automatic reg_write(input reg_idx_t idx, input sample_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Junk in the unused upper bits must be dropped by the block.
    pwdata  <= {20'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input sample_t ua, input sample_t la,
                                input sample_t ub, input sample_t lb);
    drain();
    reg_write(REG_UPPER_A, ua);
    reg_write(REG_LOWER_A, la);
    reg_write(REG_UPPER_B, ub);
    reg_write(REG_LOWER_B, lb);
    up_lvl[0] = ua;
    lo_lvl[0] = la;
    up_lvl[1] = ub;
    lo_lvl[1] = lb;
    settings_used++;
  endtask

  // Mostly encoder-like square waves of random length that cross both thresholds,
  // plus samples within two of a threshold and plain noise.
  function automatic sample_t pick_sample(input int ch);
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r >= 8) return sample_t'($urandom);
    if (r >= 6) begin
      v = int'(r == 6 ? up_lvl[ch] : lo_lvl[ch]) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return sample_t'(v);
    end
    wave_pos[ch]++;
    if (wave_pos[ch] >= wave_len[ch]) begin
      wave_pos[ch] = 0;
      wave_len[ch] = $urandom_range(2, 40);
    end
    if (wave_pos[ch] < wave_len[ch] / 2) begin
      if (up_lvl[ch] == SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
      return sample_t'($urandom_range(int'(up_lvl[ch]) + 1, SAMPLE_MAX));
    end
    if (lo_lvl[ch] == 0) return '0;
    return sample_t'($urandom_range(0, int'(lo_lvl[ch]) - 1));
  endfunction

  initial begin
    sample_t ua, la, ub, lb;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample_a = '0;
    in_sample_b = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    no_idle     = 1'b0;
    ticks_sent  = 0;
    settings_used = 1;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      up_lvl[ch]   = UPPER_RESET[ch];
      lo_lvl[ch]   = LOWER_RESET[ch];
      wave_pos[ch] = 0;
      wave_len[ch] = 8;
    end

    // Hold reset, then release it away from the rising edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed ticks against the reset thresholds (A 2500/1500, B 1000/750).
    send_tick(12'd0,    12'd0);     // both low, no period yet
    send_tick(12'd4095, 12'd4095);  // first rise: period counts from reset
    send_tick(12'd1500, 12'd750);   // sample equal to lower threshold: stay high
    send_tick(12'd1499, 12'd749);   // just below: fall
    send_tick(12'd2500, 12'd1000);  // equal to upper threshold: stay low
    send_tick(12'd2501, 12'd1001);  // just above: rise again
    send_tick(12'd4095, 12'd0);     // A holds, B falls
    send_tick(12'd0,    12'd4095);  // A falls, B rises
    send_tick(12'd4095, 12'd4095);  // A rises, B holds

    // Upper below lower: a channel in between toggles every tick.
    set_thresholds(12'd100, 12'd3000, 12'd0, 12'd4095);
    repeat (6) send_tick(12'd2000, 12'd2000);
    send_tick(12'd4095, 12'd4095);
    send_tick(12'd0, 12'd0);

    // Quiet stretch on A: arm a rise, freeze A high while B keeps running,
    // then rise again so the reported period spans the whole stretch.
    set_thresholds(12'd2000, 12'd1000, 12'd1000, 12'd750);
    send_tick(12'd0, 12'd0);
    send_tick(12'd4095, 12'd0);
    set_thresholds(12'd4095, 12'd0, 12'd1000, 12'd750);
    no_idle = 1'b1;
    repeat (QUIET_TICKS) send_tick(pick_sample(0), pick_sample(1));
    no_idle = 1'b0;
    set_thresholds(12'd2000, 12'd1000, 12'd1000, 12'd750);
    send_tick(12'd0, 12'd0);
    send_tick(12'd4095, 12'd0);

    // Random phases, each under a fresh threshold setting.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          ua = UPPER_RESET[0]; la = LOWER_RESET[0];
          ub = UPPER_RESET[1]; lb = LOWER_RESET[1];
        end
        1: begin  // extremes: A toggles on almost anything, B can never move
          ua = '0; la = sample_t'(SAMPLE_MAX);
          ub = sample_t'(SAMPLE_MAX); lb = '0;
        end
        2: begin  // ordered, random
          la = sample_t'($urandom); ua = sample_t'($urandom_range(int'(la), SAMPLE_MAX));
          lb = sample_t'($urandom); ub = sample_t'($urandom_range(int'(lb), SAMPLE_MAX));
        end
        3: begin  // inverted, random
          ua = sample_t'($urandom_range(0, SAMPLE_MAX - 1));
          la = sample_t'($urandom_range(int'(ua) + 1, SAMPLE_MAX));
          ub = sample_t'($urandom_range(0, SAMPLE_MAX - 1));
          lb = sample_t'($urandom_range(int'(ub) + 1, SAMPLE_MAX));
        end
        4: begin  // extremes: A can never rise, B rises on any nonzero and then sticks
          ua = sample_t'(SAMPLE_MAX); la = sample_t'(SAMPLE_MAX);
          ub = '0; lb = '0;
        end
        default: begin
          ua = sample_t'($urandom); la = sample_t'($urandom);
          ub = sample_t'($urandom); lb = sample_t'($urandom);
        end
      endcase
      set_thresholds(ua, la, ub, lb);
      no_idle = (p == 3);
      for (int i = 0; i < 250; i++) begin
        // Flip between paced and back-to-back stretches now and then.
        if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
        // Pause the sender once until the pipeline is empty.
        if (p == 2 && i == 125) drain();
        send_tick(pick_sample(0), pick_sample(1));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Summary: %0d ticks sent, %0d results compared over %0d threshold settings.",
             ticks_sent, checked, settings_used);
    $display("Summary: covered samples at each threshold, inverted and extreme thresholds, "
             , "and a long quiet stretch between two rises.");
    if (fail_count == 0) begin
      $display("dual_encoder_hysteresis_period regression: pass");
    end else begin
      $display("dual_encoder_hysteresis_period regression: fail");
    end
    $finish;
  end

endmodule
